[hdl/lrutc_pkg.sv]
// Shared constants and types for the LRU tile cache tag array.
package lrutc_pkg;

    localparam int CAPACITY      = 256;
    localparam int COORD_BITS    = 16;
    localparam int SLOT_BITS     = $clog2(CAPACITY);
    localparam int CNT_BITS      = $clog2(CAPACITY + 1);
    localparam int STAMP_BITS    = 32;
    localparam int LIMIT_BITS    = 9;
    localparam int FIELD_BITS    = 16;   // port width of tile_x/tile_y/evicted_x/evicted_y
    localparam int SLOT_OUT_BITS = 8;    // port width of slot

    typedef logic [COORD_BITS-1:0]    t_coord;
    typedef logic [SLOT_BITS-1:0]     t_slot;
    typedef logic [STAMP_BITS-1:0]    t_stamp;
    typedef logic [CNT_BITS-1:0]      t_count;
    typedef logic [SLOT_OUT_BITS-1:0] t_slot_out;
    typedef logic [FIELD_BITS-1:0]    t_field;

    // Search token that walks the cell chain, one cell per cycle.
    typedef struct packed {
        logic   active;
        logic   hit_found;
        t_slot  hit_idx;
        logic   old_found;
        t_stamp old_stamp;
        t_slot  old_idx;
        t_coord old_col;
        t_coord old_row;
    } t_scan;

    // Update broadcast to all cells; only the addressed cell takes it.
    typedef struct packed {
        logic   en;
        logic   set_tag;
        t_slot  idx;
        t_coord col;
        t_coord row;
        t_stamp stamp;
    } t_wr;

endpackage

[hdl/lrutc_cell.sv]
// One slot of the tag array: stored tag, stamp and valid, plus one chain stage.
module lrutc_cell import lrutc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_slot  i_idx,
    input  t_coord i_req_x,
    input  t_coord i_req_y,
    input  t_scan  i_tok,
    output t_scan  o_tok,
    input  t_wr    i_wr
);

    logic   r_valid;
    t_coord r_col;
    t_coord r_row;
    t_stamp r_stamp;
    t_scan  r_tok;
    t_scan  n_tok;
    logic   w_match;
    logic   w_older;

    assign w_match = r_valid && (r_col == i_req_x) && (r_row == i_req_y);
    // strict compare keeps the lowest slot on a stamp tie
    assign w_older = r_valid && (!i_tok.old_found || (r_stamp < i_tok.old_stamp));

    always_comb begin
        n_tok = i_tok;
        if (i_tok.active) begin
            if (w_match && !i_tok.hit_found) begin
                n_tok.hit_found = 1'b1;
                n_tok.hit_idx   = i_idx;
            end
            if (w_older) begin
                n_tok.old_found = 1'b1;
                n_tok.old_stamp = r_stamp;
                n_tok.old_idx   = i_idx;
                n_tok.old_col   = r_col;
                n_tok.old_row   = r_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_tok.active <= 1'b0;
        end else begin
            r_tok <= n_tok;
            if (i_wr.en && (i_wr.idx == i_idx)) begin
                r_valid <= 1'b1;
            end
        end
    end

    // tag and stamp storage: no reset, only read while valid
    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr.idx == i_idx)) begin
            r_stamp <= i_wr.stamp;
            if (i_wr.set_tag) begin
                r_col <= i_wr.col;
                r_row <= i_wr.row;
            end
        end
    end

    assign o_tok = r_tok;

endmodule

[hdl/lru_tile_cache_tags.sv]
// Top level of the fully associative LRU tile cache tag array.
//
// Each request word carries a tile origin (x, y). The block searches all
// CAPACITY slots by sending a token down a chain of slot cells, one cell
// per clock. Every cell checks its tag against the request and keeps the
// first hit and the oldest use stamp seen so far. The token passes the
// start register, every cell and the tail register before the result is
// written to the output register; the next request can be accepted in
// the cycle in which that result becomes valid. One request is in flight
// at a time. If the output register still holds an unaccepted result when
// a search ends, the block waits in its done state until the output
// register is free. On a hit the slot is reported and its stamp refreshed.
// On a miss the next free slot is taken while occupancy is below the
// limit; otherwise the least recently used slot (lowest slot on a stamp
// tie) is replaced and its old tile is reported. A finished result sits
// in an output register, so a new request may be accepted while it waits.
// The user must write the limit register (0 = full capacity) through the
// config channel only while the block is idle; the block does not enforce
// it. Slot valid bits clear at reset, so no clearing pass is needed.
module lru_tile_cache_tags import lrutc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,    // [15:0] tile_x, [31:16] tile_y
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,    // [0] hit, [8:1] slot, [9] need_fill, [10] evicted,
                                      // [26:11] evicted_x, [42:27] evicted_y, rest zero
    // limit register write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [8:0]  i_cfg_data    // tile_limit
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam int CMP_BITS = (CNT_BITS > LIMIT_BITS) ? CNT_BITS : LIMIT_BITS;

    logic [1:0]            r_state;
    logic [1:0]            n_state;
    logic [LIMIT_BITS-1:0] r_limit;
    t_coord                r_req_x;
    t_coord                r_req_y;
    t_scan                 r_tok0;
    t_scan                 r_tail;
    t_count                r_occ;
    t_stamp                r_stamp_cnt;

    logic                  r_out_valid;
    logic                  r_out_hit;
    t_slot_out             r_out_slot;
    logic                  r_out_evicted;
    t_field                r_out_ex;
    t_field                r_out_ey;

    t_scan                 w_tok [CAPACITY+1];
    t_scan                 w_tok_start;
    logic [CAPACITY-1:0]   w_act;
    t_wr                   w_wr;
    logic                  w_accept;
    logic                  w_out_free;
    logic                  w_commit;
    logic [CMP_BITS-1:0]   w_lim_ext;
    logic [CMP_BITS-1:0]   w_cap;
    logic [CMP_BITS-1:0]   w_eff;
    logic                  w_room;
    t_slot                 w_slot;
    logic                  w_evict;

    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_commit   = (r_state == ST_DONE) && w_out_free;

    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;

    // ---- cell chain ----
    assign w_tok[0] = r_tok0;

    // fresh token: nothing found yet, active only in the accept cycle
    always_comb begin
        w_tok_start        = '0;
        w_tok_start.active = w_accept;
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        lrutc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (t_slot'(g)),
            .i_req_x (r_req_x),
            .i_req_y (r_req_y),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1]),
            .i_wr    (w_wr)
        );
        assign w_act[g] = w_tok[g+1].active;
    end

    // ---- decision on the finished search ----
    assign w_lim_ext = CMP_BITS'(r_limit);
    assign w_cap     = CMP_BITS'(CAPACITY);
    assign w_eff     = ((r_limit == '0) || (w_lim_ext > w_cap)) ? w_cap : w_lim_ext;
    // effective limit never exceeds capacity, so this also bounds the fill
    assign w_room    = (CMP_BITS'(r_occ) < w_eff);

    always_comb begin
        w_evict = 1'b0;
        if (r_tail.hit_found) begin
            w_slot = r_tail.hit_idx;
        end else if (w_room) begin
            w_slot = r_occ[SLOT_BITS-1:0];
        end else if (r_tail.old_found) begin
            w_slot  = r_tail.old_idx;
            w_evict = 1'b1;
        end else begin
            w_slot = '0;
        end
    end

    always_comb begin
        w_wr.en      = w_commit;
        w_wr.set_tag = !r_tail.hit_found;
        w_wr.idx     = w_slot;
        w_wr.col     = r_req_x;
        w_wr.row     = r_req_y;
        w_wr.stamp   = r_stamp_cnt;
    end

    // ---- control ----
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (w_tok[CAPACITY].active) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_limit     <= '0;
            r_occ       <= '0;
            r_stamp_cnt <= '0;
            r_tok0      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_tok0  <= w_tok_start;
            if (i_cfg_valid && o_cfg_ready) begin
                r_limit <= i_cfg_data;
            end
            if (w_commit) begin
                r_stamp_cnt <= r_stamp_cnt + 1'b1;
                if (!r_tail.hit_found && w_room) begin
                    r_occ <= r_occ + 1'b1;
                end
            end
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req_x <= t_coord'(i_s_tdata[15:0]);
            r_req_y <= t_coord'(i_s_tdata[31:16]);
        end
        if ((r_state == ST_SCAN) && w_tok[CAPACITY].active) begin
            r_tail <= w_tok[CAPACITY];
        end
        if (w_commit) begin
            r_out_hit     <= r_tail.hit_found;
            r_out_slot    <= t_slot_out'(w_slot);
            r_out_evicted <= w_evict;
            r_out_ex      <= w_evict ? t_field'(r_tail.old_col) : '0;
            r_out_ey      <= w_evict ? t_field'(r_tail.old_row) : '0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_out_ey, r_out_ex, r_out_evicted, !r_out_hit,
                         r_out_slot, r_out_hit};

    // ---- checks ----
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_act))
        else $error("more than one search token in the chain");

    a_tail_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok[CAPACITY].active |-> (r_state == ST_SCAN))
        else $error("search finished outside the scan state");

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_BITS'(r_occ) <= w_cap)
        else $error("occupancy above capacity");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_DONE))
        else $error("result produced without a finished search");

endmodule
